### design/ips_pkg.sv
// Package for the interaction Pearson score block: field widths, the
// accumulator snapshot type and the default parameter values.
// No dependencies.
`timescale 1ns / 1ps
package ips_pkg;

  localparam int CNT_W   = 17;
  localparam int SX_W    = 32;
  localparam int SY_W    = 40;
  localparam int SXX_W   = 45;
  localparam int SYY_W   = 64;
  localparam int SXY_W   = 56;
  localparam int SCORE_W = 17;

  // Operand and product widths of the finalize arithmetic
  localparam int NUM_W  = 74;
  localparam int PROD_W = 2 * NUM_W;

  localparam int MAX_PATIENTS_DEF    = 65536;
  localparam int SCORE_FRAC_BITS_DEF = 16;
  localparam int Q_DEPTH             = 2;
  localparam int QCNT_W              = $clog2(Q_DEPTH + 1);

  // Sums of one finished set
  typedef struct packed {
    logic        [CNT_W-1:0] n;
    logic signed [SX_W-1:0]  sx;
    logic signed [SY_W-1:0]  sy;
    logic        [SXX_W-1:0] sxx;
    logic        [SYY_W-1:0] syy;
    logic signed [SXY_W-1:0] sxy;
  } snap_t;

endpackage

### design/ips_front.sv
// Front part: takes samples, forms the interaction value and its products,
// accumulates the sums and hands a snapshot to the queue on the last sample.
// Depends on ips_pkg.
`timescale 1ns / 1ps
module ips_front import ips_pkg::*; #(
  parameter int MAX_PATIENTS = MAX_PATIENTS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic signed [7:0]   genotype_a,
  input  logic signed [7:0]   genotype_b,
  input  logic signed [23:0]  phenotype,
  input  logic                last_sample,
  input  logic [QCNT_W-1:0]   q_used,
  output logic                q_push,
  output snap_t               q_data
);

  logic                valid1, last1, valid2, last2;
  logic signed [15:0]  x1;
  logic signed [23:0]  y1;
  logic signed [15:0]  x2;
  logic signed [23:0]  y2;
  logic        [31:0]  xx2;
  logic        [47:0]  yy2;
  logic signed [39:0]  xy2;
  snap_t               sums, sums_next;
  logic                take;
  logic [QCNT_W+1:0]   pending;

  // Room check: every last sample in flight needs a queue slot
  assign pending  = (QCNT_W+2)'(q_used) + (QCNT_W+2)'(valid1 & last1)
                  + (QCNT_W+2)'(valid2 & last2);
  assign in_ready = pending < (QCNT_W+2)'(Q_DEPTH);
  assign take     = in_valid & in_ready;

  // Stage 1: interaction product
  always_ff @(posedge clk) begin
    if (rst) begin
      valid1 <= 1'b0;
      last1  <= 1'b0;
    end else begin
      valid1 <= take;
      last1  <= last_sample;
    end
    x1 <= genotype_a * genotype_b;
    y1 <= phenotype;
  end

  // Stage 2: squares and cross product
  always_ff @(posedge clk) begin
    if (rst) begin
      valid2 <= 1'b0;
      last2  <= 1'b0;
    end else begin
      valid2 <= valid1;
      last2  <= last1;
    end
    x2  <= x1;
    y2  <= y1;
    xx2 <= 32'(x1 * x1);
    yy2 <= 48'(y1 * y1);
    xy2 <= x1 * y1;
  end

  // Stage 3: accumulate unless the set is already full
  always_comb begin
    sums_next = sums;
    if (valid2 && (sums.n < CNT_W'(MAX_PATIENTS))) begin
      sums_next.n   = sums.n + CNT_W'(1);
      sums_next.sx  = sums.sx + SX_W'(x2);
      sums_next.sy  = sums.sy + SY_W'(y2);
      sums_next.sxx = sums.sxx + SXX_W'(xx2);
      sums_next.syy = sums.syy + SYY_W'(yy2);
      sums_next.sxy = sums.sxy + SXY_W'(xy2);
    end
  end

  assign q_push = valid2 & last2;
  assign q_data = sums_next;

  always_ff @(posedge clk) begin
    if (rst || q_push) begin
      sums <= '0;
    end else begin
      sums <= sums_next;
    end
  end

endmodule

### design/ips_queue.sv
// Short queue of finished-set snapshots between front and back.
// Depends on ips_pkg.
`timescale 1ns / 1ps
module ips_queue import ips_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  snap_t             push_data,
  input  logic              pop,
  output logic              head_valid,
  output snap_t             head,
  output logic [QCNT_W-1:0] used
);

  localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;

  snap_t            entries [Q_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;

  assign head_valid = used != '0;
  assign head       = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      used   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      used <= used + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (used < QCNT_W'(Q_DEPTH)) || pop)
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> used != '0)
    else $error("queue pop while empty");
  a_level: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> used == $past(used) + QCNT_W'(1))
    else $error("queue level lost a push");

endmodule

### design/ips_back.sv
// Back part: finalizes one set. A shift-add multiplier builds the
// denominator terms and the squared numerator, then a restoring divider and
// a digit-by-digit square root give the score. Depends on ips_pkg.
`timescale 1ns / 1ps
module ips_back import ips_pkg::*; #(
  parameter int SCORE_FRAC_BITS = SCORE_FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               head_valid,
  input  snap_t              head,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [SCORE_W-1:0] score,
  output logic               degenerate,
  output logic [CNT_W-1:0]   sample_count
);

  localparam int F    = SCORE_FRAC_BITS;
  localparam int QW   = 2 * F + 2;
  localparam int RT_W = F + 1;
  localparam int SR_W = F + 4;
  localparam int CW   = $clog2(2 * F + 1);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_LOAD = 4'd1;
  localparam logic [3:0] ST_NX2  = 4'd2;
  localparam logic [3:0] ST_SX2  = 4'd3;
  localparam logic [3:0] ST_NY2  = 4'd4;
  localparam logic [3:0] ST_SY2  = 4'd5;
  localparam logic [3:0] ST_CHK  = 4'd6;
  localparam logic [3:0] ST_DM   = 4'd7;
  localparam logic [3:0] ST_PM   = 4'd8;
  localparam logic [3:0] ST_QM   = 4'd9;
  localparam logic [3:0] ST_NUM  = 4'd10;
  localparam logic [3:0] ST_NSQ  = 4'd11;
  localparam logic [3:0] ST_DIV  = 4'd12;
  localparam logic [3:0] ST_SQRT = 4'd13;
  localparam logic [3:0] ST_EMIT = 4'd14;

  logic [3:0]        state;
  snap_t             snap;
  logic [SX_W-1:0]   mx;
  logic [SY_W-1:0]   my;
  logic [SXY_W-1:0]  mxy;
  logic [PROD_W-1:0] mul_a, mul_acc;
  logic [NUM_W-1:0]  mul_b;
  logic              mul_done;
  logic [PROD_W-1:0] nx2, sx2, ny2, sy2, dm, pm, qm;
  logic [PROD_W:0]   drem;
  logic [PROD_W:0]   drem_sub;
  logic              drem_ge;
  logic [QW-1:0]     quo;
  logic [QW-1:0]     sq_src;
  logic [SR_W-1:0]   srem, srem_in, sq_trial;
  logic [RT_W-1:0]   root;
  logic [CW-1:0]     cnt;
  logic              res_deg;
  logic              pneg, qneg;
  logic [PROD_W-1:0] num_mag;

  assign mul_done = mul_b == '0;
  assign pop      = (state == ST_IDLE) && head_valid;

  // Divider step and square-root step
  assign drem_ge  = drem >= {1'b0, dm};
  assign drem_sub = drem_ge ? drem - {1'b0, dm} : drem;
  assign srem_in  = {srem[SR_W-3:0], sq_src[QW-1:QW-2]};
  assign sq_trial = {root, 2'b01};

  // Numerator magnitude from the signed product terms
  assign pneg = snap.sxy[SXY_W-1];
  assign qneg = snap.sx[SX_W-1] ^ snap.sy[SY_W-1];
  always_comb begin
    if (pneg != qneg) begin
      num_mag = pm + qm;
    end else if (pm >= qm) begin
      num_mag = pm - qm;
    end else begin
      num_mag = qm - pm;
    end
  end

  // Finalize sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != ST_EMIT) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (head_valid) begin
            snap  <= head;
            state <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          mx      <= snap.sx[SX_W-1] ? SX_W'(-snap.sx) : SX_W'(snap.sx);
          my      <= snap.sy[SY_W-1] ? SY_W'(-snap.sy) : SY_W'(snap.sy);
          mxy     <= snap.sxy[SXY_W-1] ? SXY_W'(-snap.sxy) : SXY_W'(snap.sxy);
          root    <= '0;
          res_deg <= 1'b0;
          mul_acc <= '0;
          mul_a   <= PROD_W'(snap.sxx);
          mul_b   <= NUM_W'(snap.n);
          state   <= ST_NX2;
        end
        ST_NX2, ST_SX2, ST_NY2, ST_SY2, ST_DM, ST_PM, ST_QM, ST_NSQ: begin
          if (!mul_done) begin
            if (mul_b[0]) begin
              mul_acc <= mul_acc + mul_a;
            end
            mul_a <= mul_a << 1;
            mul_b <= mul_b >> 1;
          end else begin
            mul_acc <= '0;
            priority case (state)
              ST_NX2: begin
                nx2   <= mul_acc;
                mul_a <= PROD_W'(mx);
                mul_b <= NUM_W'(mx);
                state <= ST_SX2;
              end
              ST_SX2: begin
                sx2   <= mul_acc;
                mul_a <= PROD_W'(snap.syy);
                mul_b <= NUM_W'(snap.n);
                state <= ST_NY2;
              end
              ST_NY2: begin
                ny2   <= mul_acc;
                mul_a <= PROD_W'(my);
                mul_b <= NUM_W'(my);
                state <= ST_SY2;
              end
              ST_SY2: begin
                sy2   <= mul_acc;
                state <= ST_CHK;
              end
              ST_DM: begin
                dm    <= mul_acc;
                mul_a <= PROD_W'(mxy);
                mul_b <= NUM_W'(snap.n);
                state <= ST_PM;
              end
              ST_PM: begin
                pm    <= mul_acc;
                mul_a <= PROD_W'(mx);
                mul_b <= NUM_W'(my);
                state <= ST_QM;
              end
              ST_QM: begin
                qm    <= mul_acc;
                state <= ST_NUM;
              end
              default: begin
                drem  <= {1'b0, mul_acc};
                quo   <= '0;
                cnt   <= CW'(2 * F);
                state <= ST_DIV;
              end
            endcase
          end
        end
        ST_CHK: begin
          // Non-positive variance on either side ends the set here
          if (nx2 <= sx2 || ny2 <= sy2) begin
            res_deg <= 1'b1;
            state   <= ST_EMIT;
          end else begin
            mul_a <= ny2 - sy2;
            mul_b <= NUM_W'(nx2 - sx2);
            state <= ST_DM;
          end
        end
        ST_NUM: begin
          mul_a <= num_mag;
          mul_b <= NUM_W'(num_mag);
          state <= ST_NSQ;
        end
        ST_DIV: begin
          quo  <= {quo[QW-2:0], drem_ge};
          drem <= {drem_sub[PROD_W-1:0], 1'b0};
          if (cnt == '0) begin
            sq_src <= {quo[QW-2:0], drem_ge};
            srem   <= '0;
            root   <= '0;
            cnt    <= CW'(F);
            state  <= ST_SQRT;
          end else begin
            cnt <= cnt - CW'(1);
          end
        end
        ST_SQRT: begin
          sq_src <= sq_src << 2;
          if (srem_in >= sq_trial) begin
            srem <= srem_in - sq_trial;
            root <= {root[RT_W-2:0], 1'b1};
          end else begin
            srem <= srem_in;
            root <= {root[RT_W-2:0], 1'b0};
          end
          if (cnt == '0) begin
            state <= ST_EMIT;
          end else begin
            cnt <= cnt - CW'(1);
          end
        end
        ST_EMIT: begin
          if (!out_valid || out_ready) begin
            out_valid    <= 1'b1;
            score        <= res_deg ? '0 : SCORE_W'(root);
            degenerate   <= res_deg;
            sample_count <= snap.n;
            state        <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_deg_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && degenerate) |-> score == '0)
    else $error("degenerate result with nonzero score");
  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> sample_count != '0)
    else $error("result for an empty set");
  a_root_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT && !res_deg) |-> root <= RT_W'(1 << F))
    else $error("correlation above one");
  a_div_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> drem < {dm, 1'b0})
    else $error("divider remainder out of range");

endmodule

### design/interaction_pearson_score.sv
// Interaction Pearson score. Samples stream in one per cycle while in_ready is
// high; the sums take in a sample after the interaction-product and square stages.
// A set's score follows its last sample after the finalize: eight shift-add
// products, then the divide and the root; that finalize sets the set rate.
// A two-deep queue holds finished sets so sampling continues meanwhile.
// Synchronous reset clears all sums, the queue and the output valid flag.
`timescale 1ns / 1ps
module interaction_pearson_score import ips_pkg::*; #(
  parameter int MAX_PATIENTS    = MAX_PATIENTS_DEF,
  parameter int SCORE_FRAC_BITS = SCORE_FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [7:0]  genotype_a,
  input  logic signed [7:0]  genotype_b,
  input  logic signed [23:0] phenotype,
  input  logic               last_sample,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [SCORE_W-1:0] score,
  output logic               degenerate,
  output logic [CNT_W-1:0]   sample_count
);

  logic              q_push, q_pop, q_head_valid;
  snap_t             q_data, q_head;
  logic [QCNT_W-1:0] q_used;

  ips_front #(.MAX_PATIENTS(MAX_PATIENTS)) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .genotype_a  (genotype_a),
    .genotype_b  (genotype_b),
    .phenotype   (phenotype),
    .last_sample (last_sample),
    .q_used      (q_used),
    .q_push      (q_push),
    .q_data      (q_data)
  );

  ips_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_data  (q_data),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head       (q_head),
    .used       (q_used)
  );

  ips_back #(.SCORE_FRAC_BITS(SCORE_FRAC_BITS)) u_back (
    .clk          (clk),
    .rst          (rst),
    .head_valid   (q_head_valid),
    .head         (q_head),
    .pop          (q_pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .score        (score),
    .degenerate   (degenerate),
    .sample_count (sample_count)
  );

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    q_push |-> q_used < QCNT_W'(Q_DEPTH))
    else $error("snapshot pushed into a full queue");
  a_ready_room: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> q_used < QCNT_W'(Q_DEPTH))
    else $error("sample taken with no queue room");
  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_head_valid)
    else $error("finalize started on an empty queue");

endmodule
